### rtl/cartesian_to_polar_with_range_rate_core_assert.svh
// Assertion macros used by the checker of the polar conversion core
`ifndef CARTESIAN_TO_POLAR_WITH_RANGE_RATE_CORE_ASSERT_SVH
`define CARTESIAN_TO_POLAR_WITH_RANGE_RATE_CORE_ASSERT_SVH

// same-cycle implication
`define C2P_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C2P_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/c2p_pkg.sv
`timescale 1ns / 1ps
package c2p_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int ANGLE_FRAC   = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int NORM_BIT     = 40;
	localparam int SQRT_STEPS   = 32;
	localparam int QUO_BITS     = 33;

	// vector width after normalisation, rotation width, angle width
	localparam int VW = NORM_BIT + 1;
	localparam int XW = VW + 3;
	localparam int ZW = 34;

	localparam int RND_SHIFT = ANGLE_FRAC - FRAC_BITS;

	localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
	localparam logic signed [ZW-1:0] RND_HALF = ZW'(64'sd1 <<< (RND_SHIFT - 1));
	localparam logic signed [ZW-1:0] BEAR_MAX = 34'sd262143;
	localparam logic signed [ZW-1:0] BEAR_MIN = -34'sd262144;

	// stage counts of each unit
	localparam int FRONT_LAT  = 3;
	localparam int SQRT_LAT   = SQRT_STEPS;
	localparam int DIV_LAT    = QUO_BITS + 2;
	localparam int CORDIC_LAT = 3 + CORDIC_STEPS + 1;
	localparam int BEAR_DLY   = SQRT_LAT + DIV_LAT - CORDIC_LAT;
	localparam int PIPE_LAT   = FRONT_LAT + SQRT_LAT + DIV_LAT;

	typedef struct packed {
		logic [63:0] sq;
		logic [63:0] dmag;
		logic        dneg;
		logic [31:0] ax;
		logic [31:0] ay;
		logic        xneg;
		logic        yneg;
		logic        zero;
	} front_t;

	// arctangent of 2^-i, radians Q30
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			default: v = 32'h00000000;
		endcase
		return ZW'(signed'({1'b0, v}));
	endfunction

endpackage

### rtl/c2p_front.sv
`timescale 1ns / 1ps
module c2p_front (
	input  logic           clk,
	input  logic           en,
	input  logic [31:0]    pos_x,
	input  logic [31:0]    pos_y,
	input  logic [31:0]    vel_x,
	input  logic [31:0]    vel_y,
	output c2p_pkg::front_t front
);
	import c2p_pkg::*;

	logic [31:0] px_s1, py_s1, vx_s1, vy_s1;
	logic [31:0] ax, ay, avx, avy;
	logic [63:0] pxx_s2, pyy_s2, m1_s2, m2_s2;
	logic [31:0] ax_s2, ay_s2;
	logic        n1_s2, n2_s2, xneg_s2, yneg_s2, zero_s2;
	logic [63:0] dmag;
	logic        dneg;
	front_t      front_s3;

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
		end
	end

	// magnitudes; the most negative code maps to 2^31 unsigned
	assign ax  = px_s1[31] ? 32'(-px_s1) : px_s1;
	assign ay  = py_s1[31] ? 32'(-py_s1) : py_s1;
	assign avx = vx_s1[31] ? 32'(-vx_s1) : vx_s1;
	assign avy = vy_s1[31] ? 32'(-vy_s1) : vy_s1;

	// four products, registered
	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s2  <= ax * ax;
			pyy_s2  <= ay * ay;
			m1_s2   <= ax * avx;
			m2_s2   <= ay * avy;
			n1_s2   <= px_s1[31] ^ vx_s1[31];
			n2_s2   <= py_s1[31] ^ vy_s1[31];
			ax_s2   <= ax;
			ay_s2   <= ay;
			xneg_s2 <= px_s1[31];
			yneg_s2 <= py_s1[31];
			zero_s2 <= (px_s1 == 32'd0) && (py_s1 == 32'd0);
		end
	end

	// signed dot product as sign and magnitude
	always_comb begin
		if (n1_s2 == n2_s2) begin
			dmag = m1_s2 + m2_s2;
			dneg = n1_s2;
		end else if (m1_s2 >= m2_s2) begin
			dmag = m1_s2 - m2_s2;
			dneg = n1_s2;
		end else begin
			dmag = m2_s2 - m1_s2;
			dneg = n2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s3.sq   <= pxx_s2 + pyy_s2;
			front_s3.dmag <= dmag;
			front_s3.dneg <= dneg;
			front_s3.ax   <= ax_s2;
			front_s3.ay   <= ay_s2;
			front_s3.xneg <= xneg_s2;
			front_s3.yneg <= yneg_s2;
			front_s3.zero <= zero_s2;
		end
	end

	assign front = front_s3;

endmodule

### rtl/c2p_isqrt.sv
`timescale 1ns / 1ps
module c2p_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] sq,
	output logic [31:0] root
);
	import c2p_pkg::*;

	logic [63:0] rem_s  [SQRT_STEPS];
	logic [63:0] root_s [SQRT_STEPS];

	// one result bit per stage, trial bit walking down by two
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic [63:0] s_in, r_in, bitv, trial;
		logic        ge;

		if (i == 0) begin : g_first
			assign s_in = sq;
			assign r_in = '0;
		end else begin : g_next
			assign s_in = rem_s[i-1];
			assign r_in = root_s[i-1];
		end

		assign bitv  = 64'd1 << (62 - 2 * i);
		assign trial = r_in + bitv;
		assign ge    = s_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? s_in - trial : s_in;
				root_s[i] <= ge ? (r_in >> 1) + bitv : r_in >> 1;
			end
		end
	end

	assign root = root_s[SQRT_STEPS-1][31:0];

endmodule

### rtl/c2p_div.sv
`timescale 1ns / 1ps
module c2p_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dmag,
	input  logic        dneg,
	input  logic        zero,
	input  logic [31:0] divisor,
	output logic [31:0] rate,
	output logic        sat,
	output logic        zero_out
);
	import c2p_pkg::*;

	logic [63:0]         rem_s1;
	logic [31:0]         div_s1;
	logic                neg_s1, zero_s1, ovf_s1;
	logic [63:0]         rem_s  [QUO_BITS];
	logic [QUO_BITS-1:0] quo_s  [QUO_BITS];
	logic [31:0]         dvs_s  [QUO_BITS];
	logic                neg_s  [QUO_BITS];
	logic                zero_s [QUO_BITS];
	logic                ovf_s  [QUO_BITS];
	logic [QUO_BITS-1:0] quo_f;
	logic [31:0]         rate_q;
	logic                sat_q, zero_q;

	// quotient of 2^33 or more is saturated in any case
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= dmag;
			div_s1  <= divisor;
			neg_s1  <= dneg;
			zero_s1 <= zero;
			ovf_s1  <= {1'b0, dmag} >= {divisor, 33'd0};
		end
	end

	// restoring division, one quotient bit per stage from the top
	for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
		localparam int K = QUO_BITS - 1 - j;
		logic [63:0]         r_in;
		logic [QUO_BITS-1:0] q_in;
		logic [31:0]         d_in;
		logic                n_in, z_in, o_in;
		logic [64:0]         trial;
		logic                ok;

		if (j == 0) begin : g_first
			assign r_in = rem_s1;
			assign q_in = '0;
			assign d_in = div_s1;
			assign n_in = neg_s1;
			assign z_in = zero_s1;
			assign o_in = ovf_s1;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign q_in = quo_s[j-1];
			assign d_in = dvs_s[j-1];
			assign n_in = neg_s[j-1];
			assign z_in = zero_s[j-1];
			assign o_in = ovf_s[j-1];
		end

		assign trial = {1'b0, r_in} - ({33'd0, d_in} << K);
		assign ok    = !trial[64];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ok ? trial[63:0] : r_in;
				quo_s[j]  <= ok ? (q_in | (QUO_BITS'(1) << K)) : q_in;
				dvs_s[j]  <= d_in;
				neg_s[j]  <= n_in;
				zero_s[j] <= z_in;
				ovf_s[j]  <= o_in;
			end
		end
	end

	assign quo_f = quo_s[QUO_BITS-1];

	// sign, clipping and the zero range case
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero_s[QUO_BITS-1];
			if (zero_s[QUO_BITS-1]) begin
				rate_q <= 32'd0;
				sat_q  <= 1'b0;
			end else if (!neg_s[QUO_BITS-1]) begin
				if (ovf_s[QUO_BITS-1] || quo_f > QUO_BITS'(32'h7FFF_FFFF)) begin
					rate_q <= 32'h7FFF_FFFF;
					sat_q  <= 1'b1;
				end else begin
					rate_q <= quo_f[31:0];
					sat_q  <= 1'b0;
				end
			end else begin
				if (ovf_s[QUO_BITS-1] || quo_f > QUO_BITS'(32'h8000_0000)) begin
					rate_q <= 32'h8000_0000;
					sat_q  <= 1'b1;
				end else begin
					rate_q <= 32'(-quo_f[31:0]);
					sat_q  <= 1'b0;
				end
			end
		end
	end

	assign rate     = rate_q;
	assign sat      = sat_q;
	assign zero_out = zero_q;

endmodule

### rtl/c2p_cordic.sv
`timescale 1ns / 1ps
module c2p_cordic (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] ax,
	input  logic [31:0] ay,
	input  logic        xneg,
	input  logic        yneg,
	input  logic        zero,
	output logic [18:0] bearing
);
	import c2p_pkg::*;

	logic [VW-1:0]        nv_s  [3];
	logic [VW-1:0]        na_s  [3];
	logic [VW-1:0]        nb_s  [3];
	logic signed [ZW-1:0] noff_s[3];
	logic                 nyn_s [3];
	logic                 nz_s  [3];

	logic signed [XW-1:0] x_s   [CORDIC_STEPS];
	logic signed [XW-1:0] y_s   [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s   [CORDIC_STEPS];
	logic signed [ZW-1:0] off_s [CORDIC_STEPS];
	logic                 zr_s  [CORDIC_STEPS];

	logic signed [ZW-1:0] ang, bnd;
	logic [18:0]          bear_q;

	// normalisation: leading one of the larger magnitude to bit NORM_BIT,
	// two shift decisions per stage (32,16 / 8,4 / 2,1)
	for (genvar g = 0; g < 3; g++) begin : g_norm
		localparam int KH = 32 >> (2 * g);
		localparam int KL = 16 >> (2 * g);
		logic [VW-1:0]        v_in, a_in, b_in, v1, a1, b1, v2, a2, b2;
		logic signed [ZW-1:0] o_in;
		logic                 yn_in, z_in;

		if (g == 0) begin : g_first
			assign v_in  = VW'((ax > ay) ? ax : ay);
			assign a_in  = VW'(ax);
			assign b_in  = VW'(ay);
			// left half plane: turn by pi first
			assign o_in  = xneg ? (yneg ? -PI_Q30 : PI_Q30) : '0;
			assign yn_in = xneg ? !yneg : yneg;
			assign z_in  = zero;
		end else begin : g_next
			assign v_in  = nv_s[g-1];
			assign a_in  = na_s[g-1];
			assign b_in  = nb_s[g-1];
			assign o_in  = noff_s[g-1];
			assign yn_in = nyn_s[g-1];
			assign z_in  = nz_s[g-1];
		end

		always_comb begin
			if (v_in < (VW'(1) << (VW - KH))) begin
				v1 = v_in << KH;
				a1 = a_in << KH;
				b1 = b_in << KH;
			end else begin
				v1 = v_in;
				a1 = a_in;
				b1 = b_in;
			end
			if (v1 < (VW'(1) << (VW - KL))) begin
				v2 = v1 << KL;
				a2 = a1 << KL;
				b2 = b1 << KL;
			end else begin
				v2 = v1;
				a2 = a1;
				b2 = b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nv_s[g]   <= v2;
				na_s[g]   <= a2;
				nb_s[g]   <= b2;
				noff_s[g] <= o_in;
				nyn_s[g]  <= yn_in;
				nz_s[g]   <= z_in;
			end
		end
	end

	// vectoring micro-rotations, one per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [XW-1:0] x_in, y_in, dx, dy;
		logic signed [ZW-1:0] z_in, o_in, at;
		logic                 zr_in;

		if (i == 0) begin : g_first
			assign x_in  = signed'(XW'(na_s[2]));
			assign y_in  = nyn_s[2] ? -signed'(XW'(nb_s[2])) : signed'(XW'(nb_s[2]));
			assign z_in  = '0;
			assign o_in  = noff_s[2];
			assign zr_in = nz_s[2];
		end else begin : g_next
			assign x_in  = x_s[i-1];
			assign y_in  = y_s[i-1];
			assign z_in  = z_s[i-1];
			assign o_in  = off_s[i-1];
			assign zr_in = zr_s[i-1];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign at = atan_q30(5'(i));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[XW-1]) begin
					x_s[i] <= x_in + dx;
					y_s[i] <= y_in - dy;
					z_s[i] <= z_in + at;
				end else begin
					x_s[i] <= x_in - dx;
					y_s[i] <= y_in + dy;
					z_s[i] <= z_in - at;
				end
				off_s[i] <= o_in;
				zr_s[i]  <= zr_in;
			end
		end
	end

	// round half up to FRAC_BITS and clip to the output range
	assign ang = z_s[CORDIC_STEPS-1] + off_s[CORDIC_STEPS-1] + RND_HALF;
	assign bnd = ang >>> RND_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zr_s[CORDIC_STEPS-1])
				bear_q <= '0;
			else if (bnd > BEAR_MAX)
				bear_q <= BEAR_MAX[18:0];
			else if (bnd < BEAR_MIN)
				bear_q <= BEAR_MIN[18:0];
			else
				bear_q <= bnd[18:0];
		end
	end

	assign bearing = bear_q;

endmodule

### rtl/cartesian_to_polar_with_range_rate_core.sv
`timescale 1ns / 1ps
// Cartesian state to polar measurement: range, bearing and range rate.
// Input stream s_*: one request per state vector (pos_x, pos_y, vel_x,
// vel_y, signed Q16.16). Output stream m_*: one request per input, in order,
// carrying range (unsigned Q16.16), bearing (radians, signed, 16 fraction
// bits), range rate (signed Q16.16) and two flags.
// Throughput: one request per clock while the output is not held. Latency: 70
// register stages, set by the 3-stage front end, the 32-stage square root
// and the 35-stage restoring divider; the 34-stage CORDIC runs beside them.
// Zero range (both positions zero) gives range, bearing and rate of zero
// with zero_range set; a clipped rate sets rate_saturated.
// Reset clears the valid bits only; no request is in flight afterwards.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
module cartesian_to_polar_with_range_rate_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// range[31:0], bearing[50:32], range_rate[82:51], zero_range[83],
	// rate_saturated[84], zero[87:85]
	output logic [87:0]  m_tdata
);
	import c2p_pkg::*;

	logic [PIPE_LAT-1:0] vld_s;
	logic                en;
	front_t              front;
	logic [31:0]         root;
	logic [18:0]         bear;
	logic [31:0]         rate;
	logic                sat, zero_f;

	logic [63:0] dmag_d [SQRT_LAT];
	logic        dneg_d [SQRT_LAT];
	logic        zero_d [SQRT_LAT];
	logic [31:0] rng_d  [DIV_LAT];
	logic [18:0] bear_d [BEAR_DLY];

	// whole pipeline advances unless the output is held
	assign en       = !vld_s[PIPE_LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], s_tvalid};
		end
	end

	c2p_front u_front (
		.clk   (clk),
		.en    (en),
		.pos_x (s_tdata[31:0]),
		.pos_y (s_tdata[63:32]),
		.vel_x (s_tdata[95:64]),
		.vel_y (s_tdata[127:96]),
		.front (front)
	);

	c2p_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sq   (front.sq),
		.root (root)
	);

	c2p_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.ax      (front.ax),
		.ay      (front.ay),
		.xneg    (front.xneg),
		.yneg    (front.yneg),
		.zero    (front.zero),
		.bearing (bear)
	);

	// align dot product with the root
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_d[0] <= front.dmag;
			dneg_d[0] <= front.dneg;
			zero_d[0] <= front.zero;
			for (int i = 1; i < SQRT_LAT; i++) begin
				dmag_d[i] <= dmag_d[i-1];
				dneg_d[i] <= dneg_d[i-1];
				zero_d[i] <= zero_d[i-1];
			end
		end
	end

	c2p_div u_div (
		.clk      (clk),
		.en       (en),
		.dmag     (dmag_d[SQRT_LAT-1]),
		.dneg     (dneg_d[SQRT_LAT-1]),
		.zero     (zero_d[SQRT_LAT-1]),
		.divisor  (root),
		.rate     (rate),
		.sat      (sat),
		.zero_out (zero_f)
	);

	// align range and bearing with the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rng_d[0]  <= root;
			bear_d[0] <= bear;
			for (int i = 1; i < DIV_LAT; i++)
				rng_d[i] <= rng_d[i-1];
			for (int i = 1; i < BEAR_DLY; i++)
				bear_d[i] <= bear_d[i-1];
		end
	end

	assign m_tdata = {3'd0, sat, zero_f, rate, bear_d[BEAR_DLY-1], rng_d[DIV_LAT-1]};

endmodule

### rtl/c2p_checker.sv
`timescale 1ns / 1ps
`include "cartesian_to_polar_with_range_rate_core_assert.svh"
module c2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);

	// zero range forces all values to zero
	`C2P_ASSERT_IMP(a_zero_vals, clk, arst_n, m_tvalid && m_tdata[83], (m_tdata[31:0] == 32'd0) && (m_tdata[50:32] == 19'd0) && (m_tdata[82:51] == 32'd0), "zero range with non-zero values")

	// a range of zero only arises from the origin
	`C2P_ASSERT_IMP(a_range_zero, clk, arst_n, m_tvalid && (m_tdata[31:0] == 32'd0), m_tdata[83], "zero range not flagged")

	// saturation sits on a bound and never with zero range
	`C2P_ASSERT_IMP(a_sat_bound, clk, arst_n, m_tvalid && m_tdata[84], !m_tdata[83] && ((m_tdata[82:51] == 32'h7FFF_FFFF) || (m_tdata[82:51] == 32'h8000_0000)), "bad saturated rate")

	// held result stays put
	`C2P_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed under stall")

endmodule

bind cartesian_to_polar_with_range_rate_core c2p_checker u_chk (.*);

### tb/tb_cartesian_to_polar_with_range_rate_core.sv
`timescale 1ns / 1ps
module tb_cartesian_to_polar_with_range_rate_core;

	localparam int LATENCY  = 70;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 900;

	// first member sits in the top bits
	typedef struct packed {
		logic        rate_sat;
		logic        zero_range;
		logic [31:0] rate;
		logic [18:0] bearing;
		logic [31:0] rng;
	} polar_t;

	// arctangent of 2^-i in Q30 radians
	function automatic longint atan_step(input int i);
		longint t [30] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
		return t[i];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring CORDIC, Q30 angle; vector must be non-zero
	function automatic longint bearing_q30(input longint px, input longint py);
		longint off, x, y, z, dx, dy;
		longint unsigned ax, ay, m;
		bit yneg;
		int sh;
		off = 0;
		z = 0;
		yneg = py < 0;
		ax = px < 0 ? -px : px;
		ay = py < 0 ? -py : py;
		if (px < 0) begin
			off = yneg ? -64'sd3373259426 : 64'sd3373259426;
			yneg = !yneg;
		end
		m = ax > ay ? ax : ay;
		sh = 0;
		while ((m << sh) < (64'd1 << 40))
			sh++;
		x = ax << sh;
		y = ay << sh;
		if (yneg)
			y = -y;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		return z + off;
	endfunction

	function automatic polar_t polar_of(input logic [127:0] d);
		longint px, py, vx, vy, b;
		longint unsigned r, m1, m2, mg, q;
		bit n1, n2, neg;
		polar_t p;
		px = longint'($signed(d[31:0]));
		py = longint'($signed(d[63:32]));
		vx = longint'($signed(d[95:64]));
		vy = longint'($signed(d[127:96]));
		m1 = px < 0 ? -px : px;
		m2 = py < 0 ? -py : py;
		r = int_sqrt(m1 * m1 + m2 * m2);
		p = '0;
		p.rng = r[31:0];
		if (px == 0 && py == 0) begin
			p.zero_range = 1'b1;
			return p;
		end
		b = (bearing_q30(px, py) + (64'sd1 <<< 13)) >>> 14;
		if (b > 262143) b = 262143;
		if (b < -262144) b = -262144;
		p.bearing = b[18:0];
		n1 = (px < 0) != (vx < 0);
		n2 = (py < 0) != (vy < 0);
		m1 = (px < 0 ? -px : px) * (vx < 0 ? -vx : vx);
		m2 = (py < 0 ? -py : py) * (vy < 0 ? -vy : vy);
		if (n1 == n2) begin
			mg = m1 + m2; neg = n1;
		end else if (m1 >= m2) begin
			mg = m1 - m2; neg = n1;
		end else begin
			mg = m2 - m1; neg = n2;
		end
		q = mg / r;
		if (!neg && q > 64'd2147483647) begin
			q = 64'd2147483647; p.rate_sat = 1'b1;
		end
		if (neg && q > 64'd2147483648) begin
			q = 64'd2147483648; p.rate_sat = 1'b1;
		end
		p.rate = neg ? -q[31:0] : q[31:0];
		return p;
	endfunction

	class polar_board;
		polar_t pending [$];
		int errors;
		int checked;

		function void note_state(input logic [127:0] d);
			pending.push_back(polar_of(d));
		endfunction

		function void check_result(input logic [87:0] d);
			polar_t e, a;
			a = d[84:0];
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			if (a !== e || d[87:85] !== 3'b000) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp rng %h brg %h rate %h z %b s %b / ",
						"got rng %h brg %h rate %h z %b s %b pad %b"},
						e.rng, e.bearing, e.rate, e.zero_range, e.rate_sat,
						a.rng, a.bearing, a.rate, a.zero_range, a.rate_sat, d[87:85]);
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;

	polar_board board = new();
	bit         sending_done = 1'b0;
	int         idle_cycles = 0;
	int         hold_cnt = 0;

	cartesian_to_polar_with_range_rate_core dut (.*);

	always #5 clk = ~clk;

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0)
			return 0;
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? $urandom_range(0, 1024) : -$urandom_range(0, 1024);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_state(input logic [127:0] d);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		board.note_state(d);
	endtask

	task automatic send_with_gap(input logic [127:0] d);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		send_state(d);
	endtask

	// output side: mostly short stalls, now and then a long one
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (hold_cnt > 0) begin
				m_tready <= 1'b0;
				hold_cnt <= hold_cnt - 1;
			end else if ($urandom_range(0, 60) == 0) begin
				m_tready <= 1'b0;
				hold_cnt <= $urandom_range(10, 60);
			end else begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// watchdog on cycles with no handshake on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !(sending_done && board.pending.size() == 0)) begin
			$display("FAIL cartesian_to_polar_with_range_rate_core");
			$finish;
		end
	end

	initial begin
		logic [31:0] w [4];
		int n_dir;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero range, axes, pi boundary, extremes, saturation
		send_state({32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0});
		send_state({32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0});
		send_state({32'h0, 32'h0, 32'h0, 32'h0001_0000});
		send_state({32'h0, 32'h0, 32'h0, 32'hFFFF_0000});
		send_state({32'h0, 32'h0, 32'h0, 32'h8000_0000});
		send_state({32'h0, 32'h0, 32'h0001_0000, 32'h0});
		send_state({32'h0, 32'h0, 32'hFFFF_0000, 32'h0});
		send_state({32'h0, 32'h0, 32'h0, 32'h0000_0001});
		send_state({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_state({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_state({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
		send_state({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001});
		send_state({32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001});
		send_state({32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0000_0001});
		send_state({32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0});
		send_state({32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0});
		send_state({32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		n_dir = 17;
		// random states, mixing extremes with full-range words
		for (int i = 0; i < N_RANDOM; i++) begin
			foreach (w[k])
				w[k] = rand_word();
			send_with_gap({w[3], w[2], w[1], w[0]});
		end
		s_tvalid <= 1'b0;
		sending_done = 1'b1;
		wait (board.pending.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d directed and %0d random states, %0d results checked",
			n_dir, N_RANDOM, board.checked);
		if (board.errors == 0)
			$display("PASS cartesian_to_polar_with_range_rate_core");
		else
			$display("FAIL cartesian_to_polar_with_range_rate_core");
		$finish;
	end

endmodule
